>>> rtl/core/atmg_pkg.sv
// Shared types, constants and gamma lookup tables for the ACES tone mapper.
package atmg_pkg;

    typedef struct packed {
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
    } result_t;

    localparam int NUM_LANES  = 3;
    localparam int DIV_STEPS  = 32;
    localparam int FQ_DELAY   = 10;
    localparam int CAND_DELAY = 6;
    localparam int PIPE_DEPTH = 4 + DIV_STEPS + 6 + 7;

    localparam logic [15:0] EXPOSURE_RESET = 16'd256;

    localparam logic [7:0] CURVE_A = 8'd251;
    localparam logic [7:0] CURVE_B = 8'd3;
    localparam logic [7:0] CURVE_C = 8'd243;
    localparam logic [7:0] CURVE_D = 8'd59;
    localparam logic [7:0] CURVE_E = 8'd14;

    localparam logic [31:0] QUOT_LIMIT = 32'h8500_0000;

    typedef logic [24:0] gtab_t [0:256];
    typedef logic [24:0] ptab_t [0:31];

    // mantissa^(5/11) for mantissa in [1,2], 24 fraction bits
    function automatic gtab_t gamma_tab();
        gtab_t t;
        real   v;
        for (int i = 0; i <= 256; i++)
        begin
            v = $pow(1.0 + real'(i) / 256.0, 5.0 / 11.0) * 16777216.0;
            t[i] = 25'($rtoi(v + 0.5));
        end
        return t;
    endfunction

    // 2^(-5k/11), 24 fraction bits
    function automatic ptab_t pow_tab();
        ptab_t t;
        real   v;
        for (int i = 0; i < 32; i++)
        begin
            v = $pow(2.0, -5.0 * real'(i) / 11.0) * 16777216.0;
            t[i] = 25'($rtoi(v + 0.5));
        end
        return t;
    endfunction

    localparam gtab_t GAMMA_TAB = gamma_tab();
    localparam ptab_t POW_TAB   = pow_tab();

endpackage

>>> rtl/core/aces_tone_map_gamma.sv
// ACES filmic tone mapper with gamma 2.2, fully pipelined over three color lanes.
//
// One pixel request is taken every clock cycle; busy is always low and the
// exposure write channel is always ready. Each result appears on result with a
// one-cycle done strobe after its request passes through exposure scaling and
// curve terms, a 32-stage restoring divider for the curve quotient, table-based
// root estimation and exact eleventh-power checks that fix the last bit. The
// receiver cannot stall the block, so every result must be captured in the cycle
// done is high. Write exposure only while no request is in flight.
module aces_tone_map_gamma (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  atmg_pkg::pixel_t  pixel,
    input  logic              exposure_valid,
    output logic              exposure_ready,
    input  logic [15:0]       exposure,
    output logic              done,
    output atmg_pkg::result_t result
);
    import atmg_pkg::*;

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [15:0]           exposure_reg;

    logic [15:0]  comp      [NUM_LANES];
    logic [31:0]  x_reg     [NUM_LANES];
    logic [3:0]   s_next    [NUM_LANES];
    logic [23:0]  y_reg     [NUM_LANES];
    logic [4:0]   fb_reg    [NUM_LANES];
    logic [31:0]  a1_reg    [NUM_LANES];
    logic [31:0]  b1_reg    [NUM_LANES];
    logic [35:0]  c0_reg    [NUM_LANES];
    logic [23:0]  y3_reg    [NUM_LANES];
    logic [55:0]  num_reg   [NUM_LANES];
    logic [56:0]  den_reg   [NUM_LANES];

    logic [56:0]  dr_reg    [NUM_LANES][DIV_STEPS];
    logic [31:0]  dq_reg    [NUM_LANES][DIV_STEPS];
    logic [56:0]  dd_reg    [NUM_LANES][DIV_STEPS];
    logic [56:0]  dr_next   [NUM_LANES][DIV_STEPS];
    logic [31:0]  dq_next   [NUM_LANES][DIV_STEPS];

    logic [4:0]   lz_next   [NUM_LANES];
    logic [4:0]   lz_reg    [NUM_LANES][4];
    logic         zr_reg    [NUM_LANES][5];
    logic [31:0]  fqd_reg   [NUM_LANES][FQ_DELAY];
    logic [31:0]  m_reg     [NUM_LANES];
    logic [24:0]  t0_reg    [NUM_LANES];
    logic [15:0]  dlt_reg   [NUM_LANES];
    logic [15:0]  frac_reg  [NUM_LANES];
    logic [24:0]  v_reg     [NUM_LANES];
    logic [49:0]  e_reg     [NUM_LANES];
    logic [15:0]  c_next    [NUM_LANES];
    logic [15:0]  cand_reg  [NUM_LANES][2];

    logic [15:0]  xc_reg    [NUM_LANES][2][CAND_DELAY];
    logic [31:0]  x2_reg    [NUM_LANES][2];
    logic [63:0]  x4_reg    [NUM_LANES][2];
    logic [47:0]  x3_reg    [NUM_LANES][2];
    logic [63:0]  pp0_reg   [NUM_LANES][2];
    logic [47:0]  pp1_reg   [NUM_LANES][2];
    logic [63:0]  pp2_reg   [NUM_LANES][2];
    logic [47:0]  pp3_reg   [NUM_LANES][2];
    logic [63:0]  x4b_reg   [NUM_LANES][2];
    logic [111:0] x7_reg    [NUM_LANES][2];
    logic [63:0]  x4c_reg   [NUM_LANES][2];
    logic [63:0]  pq_reg    [NUM_LANES][2][8];
    logic [175:0] x11_next  [NUM_LANES][2];
    logic [175:0] x11_reg   [NUM_LANES][2];

    logic [63:0]  f2_reg    [NUM_LANES];
    logic [63:0]  fll_reg   [NUM_LANES];
    logic [63:0]  flh_reg   [NUM_LANES];
    logic [63:0]  fhh_reg   [NUM_LANES];
    logic [127:0] f4_reg    [NUM_LANES];
    logic [63:0]  fp_reg    [NUM_LANES][4];
    logic [159:0] f5_next   [NUM_LANES];
    logic [159:0] f5_reg    [NUM_LANES];

    logic [175:0] t_cmp     [NUM_LANES];
    logic [15:0]  res_next  [NUM_LANES];
    logic [NUM_LANES-1:0] low_miss;
    logic [15:0]  res_reg   [NUM_LANES];

    assign busy           = 1'b0;
    assign exposure_ready = 1'b1;
    assign done           = valid_reg[PIPE_DEPTH-1];

    assign comp[0] = pixel.red_in;
    assign comp[1] = pixel.green_in;
    assign comp[2] = pixel.blue_in;

    assign result.red_out   = res_reg[0];
    assign result.green_out = res_reg[1];
    assign result.blue_out  = res_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            exposure_reg <= EXPOSURE_RESET;
        end
        else
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], start};
            if (exposure_valid)
            begin
                exposure_reg <= exposure;
            end
        end
    end

    always_comb
    begin
        logic [57:0]  dsh;
        logic         dge;
        for (int ln = 0; ln < NUM_LANES; ln++)
        begin
            s_next[ln] = '0;
            for (int i = 24; i < 32; i++)
            begin
                if (x_reg[ln][i])
                begin
                    s_next[ln] = 4'(i - 23);
                end
            end

            dsh = 58'(num_reg[ln]);
            dge = dsh >= 58'(den_reg[ln]);
            dr_next[ln][0] = dge ? 57'(dsh - 58'(den_reg[ln])) : 57'(dsh);
            dq_next[ln][0] = {31'd0, dge};
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                dsh = {dr_reg[ln][k-1], 1'b0};
                dge = dsh >= 58'(dd_reg[ln][k-1]);
                dr_next[ln][k] = dge ? 57'(dsh - 58'(dd_reg[ln][k-1])) : 57'(dsh);
                dq_next[ln][k] = {dq_reg[ln][k-1][30:0], dge};
            end

            lz_next[ln] = '0;
            for (int i = 0; i < 32; i++)
            begin
                if (dq_reg[ln][DIV_STEPS-1][i])
                begin
                    lz_next[ln] = 5'(31 - i);
                end
            end

            c_next[ln] = zr_reg[ln][4] ? 16'd0 : e_reg[ln][48:33];

            for (int cd = 0; cd < 2; cd++)
            begin
                x11_next[ln][cd] = '0;
                for (int i = 0; i < 4; i++)
                begin
                    x11_next[ln][cd] = x11_next[ln][cd]
                        + (176'(pq_reg[ln][cd][2*i]) << (32 * i))
                        + (176'(pq_reg[ln][cd][2*i+1]) << (32 * i + 32));
                end
            end

            f5_next[ln] = '0;
            for (int i = 0; i < 4; i++)
            begin
                f5_next[ln] = f5_next[ln] + (160'(fp_reg[ln][i]) << (32 * i));
            end

            t_cmp[ln] = 176'(f5_reg[ln]) << 10;
            low_miss[ln] = (x11_reg[ln][0] > t_cmp[ln]) && (xc_reg[ln][0][CAND_DELAY-1] == '0);
            if (x11_reg[ln][1] <= t_cmp[ln])
            begin
                res_next[ln] = xc_reg[ln][1][CAND_DELAY-1];
            end
            else if (x11_reg[ln][0] <= t_cmp[ln])
            begin
                res_next[ln] = xc_reg[ln][0][CAND_DELAY-1];
            end
            else
            begin
                res_next[ln] = 16'(xc_reg[ln][0][CAND_DELAY-1] - 16'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int ln = 0; ln < NUM_LANES; ln++)
        begin
            x_reg[ln]   <= 32'(comp[ln]) * 32'(exposure_reg);
            y_reg[ln]   <= 24'(x_reg[ln] >> s_next[ln]);
            fb_reg[ln]  <= 5'(5'd16 - 5'(s_next[ln]));
            a1_reg[ln]  <= 32'(y_reg[ln]) * 32'(CURVE_A) + (32'(CURVE_B) << fb_reg[ln]);
            b1_reg[ln]  <= 32'(y_reg[ln]) * 32'(CURVE_C) + (32'(CURVE_D) << fb_reg[ln]);
            c0_reg[ln]  <= 36'(CURVE_E) << {fb_reg[ln], 1'b0};
            y3_reg[ln]  <= y_reg[ln];
            num_reg[ln] <= 56'(y3_reg[ln]) * 56'(a1_reg[ln]);
            den_reg[ln] <= 57'(y3_reg[ln]) * 57'(b1_reg[ln]) + 57'(c0_reg[ln]);

            for (int k = 0; k < DIV_STEPS; k++)
            begin
                dr_reg[ln][k] <= dr_next[ln][k];
                dq_reg[ln][k] <= dq_next[ln][k];
                dd_reg[ln][k] <= (k == 0) ? den_reg[ln] : dd_reg[ln][(k == 0) ? 0 : k - 1];
            end

            lz_reg[ln][0]  <= lz_next[ln];
            zr_reg[ln][0]  <= dq_reg[ln][DIV_STEPS-1] == '0;
            fqd_reg[ln][0] <= dq_reg[ln][DIV_STEPS-1];
            for (int j = 1; j < 4; j++)
            begin
                lz_reg[ln][j] <= lz_reg[ln][j-1];
            end
            for (int j = 1; j < 5; j++)
            begin
                zr_reg[ln][j] <= zr_reg[ln][j-1];
            end
            for (int j = 1; j < FQ_DELAY; j++)
            begin
                fqd_reg[ln][j] <= fqd_reg[ln][j-1];
            end

            m_reg[ln]    <= fqd_reg[ln][0] << lz_reg[ln][0];
            t0_reg[ln]   <= GAMMA_TAB[9'(m_reg[ln][30:23])];
            dlt_reg[ln]  <= 16'(GAMMA_TAB[9'(m_reg[ln][30:23]) + 9'd1]
                                - GAMMA_TAB[9'(m_reg[ln][30:23])]);
            frac_reg[ln] <= m_reg[ln][22:7];
            v_reg[ln]    <= t0_reg[ln] + 25'((32'(dlt_reg[ln]) * 32'(frac_reg[ln])) >> 16);
            e_reg[ln]    <= 50'(v_reg[ln]) * 50'(POW_TAB[lz_reg[ln][3]]);
            cand_reg[ln][0] <= c_next[ln];
            cand_reg[ln][1] <= 16'(c_next[ln] + 16'd1);

            for (int cd = 0; cd < 2; cd++)
            begin
                xc_reg[ln][cd][0] <= cand_reg[ln][cd];
                for (int j = 1; j < CAND_DELAY; j++)
                begin
                    xc_reg[ln][cd][j] <= xc_reg[ln][cd][j-1];
                end
                x2_reg[ln][cd]  <= 32'(cand_reg[ln][cd]) * 32'(cand_reg[ln][cd]);
                x4_reg[ln][cd]  <= 64'(x2_reg[ln][cd]) * 64'(x2_reg[ln][cd]);
                x3_reg[ln][cd]  <= 48'(x2_reg[ln][cd]) * 48'(xc_reg[ln][cd][0]);
                pp0_reg[ln][cd] <= 64'(x4_reg[ln][cd][31:0]) * 64'(x3_reg[ln][cd][31:0]);
                pp1_reg[ln][cd] <= 48'(x4_reg[ln][cd][31:0]) * 48'(x3_reg[ln][cd][47:32]);
                pp2_reg[ln][cd] <= 64'(x4_reg[ln][cd][63:32]) * 64'(x3_reg[ln][cd][31:0]);
                pp3_reg[ln][cd] <= 48'(x4_reg[ln][cd][63:32]) * 48'(x3_reg[ln][cd][47:32]);
                x4b_reg[ln][cd] <= x4_reg[ln][cd];
                x7_reg[ln][cd]  <= 112'(pp0_reg[ln][cd]) + (112'(pp1_reg[ln][cd]) << 32)
                                   + (112'(pp2_reg[ln][cd]) << 32)
                                   + (112'(pp3_reg[ln][cd]) << 64);
                x4c_reg[ln][cd] <= x4b_reg[ln][cd];
                for (int i = 0; i < 4; i++)
                begin
                    pq_reg[ln][cd][2*i]   <= 64'((128'(x7_reg[ln][cd]) >> (32 * i)) & 128'hFFFF_FFFF)
                                             * 64'(x4c_reg[ln][cd][31:0]);
                    pq_reg[ln][cd][2*i+1] <= 64'((128'(x7_reg[ln][cd]) >> (32 * i)) & 128'hFFFF_FFFF)
                                             * 64'(x4c_reg[ln][cd][63:32]);
                end
                x11_reg[ln][cd] <= x11_next[ln][cd];
            end

            f2_reg[ln]  <= 64'(fqd_reg[ln][6]) * 64'(fqd_reg[ln][6]);
            fll_reg[ln] <= 64'(f2_reg[ln][31:0]) * 64'(f2_reg[ln][31:0]);
            flh_reg[ln] <= 64'(f2_reg[ln][31:0]) * 64'(f2_reg[ln][63:32]);
            fhh_reg[ln] <= 64'(f2_reg[ln][63:32]) * 64'(f2_reg[ln][63:32]);
            f4_reg[ln]  <= 128'(fll_reg[ln]) + (128'(flh_reg[ln]) << 33)
                           + (128'(fhh_reg[ln]) << 64);
            for (int i = 0; i < 4; i++)
            begin
                fp_reg[ln][i] <= 64'(f4_reg[ln][32*i +: 32]) * 64'(fqd_reg[ln][FQ_DELAY-1]);
            end
            f5_reg[ln]  <= f5_next[ln];

            res_reg[ln] <= res_next[ln];
        end
    end

`ifndef NO_ASSERTIONS
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PIPE_DEPTH))
        else $error("result strobe without matching request");

    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[4 + DIV_STEPS - 1] |->
            (dq_reg[0][DIV_STEPS-1] < QUOT_LIMIT) && (dq_reg[1][DIV_STEPS-1] < QUOT_LIMIT)
            && (dq_reg[2][DIV_STEPS-1] < QUOT_LIMIT))
        else $error("curve quotient out of range");

    a_root_low: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[PIPE_DEPTH-2] |-> (low_miss == '0))
        else $error("root estimate below zero");
`endif

endmodule
